### rtl/rrss_pkg.sv
// ----------------------------------------------------------------------------
// rrss_pkg
// shared types and constants for the reference-counted ring slot store
// ----------------------------------------------------------------------------
package rrss_pkg;

  // default parameter values
  localparam int DEPTH_DEF     = 256;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths
  localparam int SLOT_W     = 8;
  localparam int ID_W       = 32;
  localparam int IN_TIME_W  = 32;
  localparam int REFS_W     = 16;
  localparam int CNT_W      = 9;
  localparam int SIZE_W     = 9;
  localparam int SIZE_MAX   = 511;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // register reset values and the reference count maximum
  localparam logic [SIZE_W-1:0] SIZE_RST  = 9'd256;
  localparam logic [31:0]       YOUTH_RST = 32'd1000000;
  localparam logic [REFS_W-1:0] REFS_MAX  = 16'hFFFF;
  localparam logic [ID_W-1:0]   ID_RST    = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STORE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YOUTH_TIME     = 1'd1;

  typedef enum logic [1:0] {
    CMD_CREATE   = 2'd0,
    CMD_ADD_REF  = 2'd1,
    CMD_DROP_REF = 2'd2,
    CMD_SWEEP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SLOT_EMPTY = 2'd1,
    ST_OUT_RANGE  = 2'd2,
    ST_REFS_ZERO  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RMW   = 4'b0100,
    S_SWEEP = 4'b1000
  } state_t;

endpackage

### rtl/refcounted_ring_slot_store.sv
// ----------------------------------------------------------------------------
// refcounted_ring_slot_store
// ring of packet-buffer slots with reference counts, round-robin create,
// reference add/drop and an age-based sweep of unreferenced slots
// ----------------------------------------------------------------------------
// usage
//   request channel: a command is taken at a rising edge with start high and
//   busy low (cmd, slot, arrival_time, now_time sampled at that edge)
//   result channel: out_valid is high for exactly one cycle per request with
//   all out_ fields; the receiver cannot stall, so results never back up
//   config channel: cfg_valid/cfg_ready write, index 0 max_store_size,
//   index 1 youth_time; cfg_ready is always high; the user must issue writes
//   only while idle, and the block does not enforce it
//   create, add, drop: one read-modify-write of the slot memory; the request
//   goes to the RMW state, the result strobe is registered from it, and the
//   next request can be taken while the strobe is high
//   sweep: walks the slots in use through the memory read port one per cycle
//   reset: the slot memory is cleared one entry per cycle after reset, with
//   busy high; config writes are taken meanwhile
// ----------------------------------------------------------------------------
module refcounted_ring_slot_store #(
  parameter int DEPTH     = rrss_pkg::DEPTH_DEF,
  parameter int TIME_BITS = rrss_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_cmd,
  input  logic [rrss_pkg::SLOT_W-1:0]         in_slot,
  input  logic [rrss_pkg::IN_TIME_W-1:0]      in_arrival_time,
  input  logic [rrss_pkg::IN_TIME_W-1:0]      in_now_time,
  // result channel
  output logic                                out_valid,
  output logic [rrss_pkg::SLOT_W-1:0]         out_slot_used,
  output logic [rrss_pkg::ID_W-1:0]           out_store_id,
  output logic [1:0]                          out_status,
  output logic                                out_replaced,
  output logic [rrss_pkg::CNT_W-1:0]          out_purged_count,
  output logic [rrss_pkg::CNT_W-1:0]          out_entry_count,
  output logic [rrss_pkg::REFS_W-1:0]         out_refs_after,
  // config channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W    = $clog2(DEPTH);
  localparam int REFS_W   = rrss_pkg::REFS_W;
  localparam int SIZE_W   = rrss_pkg::SIZE_W;
  localparam int CNT_W    = rrss_pkg::CNT_W;
  localparam int ENT_W    = TIME_BITS + REFS_W + 1;
  localparam int SIZE_CAP = (DEPTH > rrss_pkg::SIZE_MAX) ? rrss_pkg::SIZE_MAX : DEPTH;
  localparam int CMP_W    = (TIME_BITS > 32) ? TIME_BITS : 32;

  // entry layout: valid | refs | created
  localparam int V_BIT = ENT_W - 1;
  localparam int R_LSB = TIME_BITS;

  // slot memory, one entry per slot
  logic [ENT_W-1:0] mem [DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // control state
  rrss_pkg::state_t       state_r, state_nxt;
  logic [IDX_W-1:0]       clr_r, clr_nxt;
  logic [IDX_W-1:0]       next_slot_r, next_slot_nxt;
  logic [rrss_pkg::ID_W-1:0] next_id_r, next_id_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]      sw_rd_r, sw_rd_nxt;
  logic [SIZE_W-1:0]      sw_proc_r, sw_proc_nxt;
  logic [CNT_W-1:0]       purged_r, purged_nxt;

  // configuration registers
  logic [SIZE_W-1:0]      max_size_r;
  logic [31:0]            youth_r;

  // captured request
  rrss_pkg::cmd_t         cmd_r;
  logic [rrss_pkg::SLOT_W-1:0] slot_r;
  logic [IDX_W-1:0]       tgt_r;
  logic [TIME_BITS-1:0]   arrival_r;
  logic [TIME_BITS-1:0]   now_r;

  // result registers
  logic                   out_valid_r, out_valid_nxt;
  logic [rrss_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [rrss_pkg::ID_W-1:0]   out_id_r, out_id_nxt;
  rrss_pkg::status_t      out_status_r, out_status_nxt;
  logic                   out_repl_r, out_repl_nxt;
  logic [CNT_W-1:0]       out_purged_r, out_purged_nxt;
  logic [CNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic [REFS_W-1:0]      out_refs_r, out_refs_nxt;

  // effective ring size, clamped to 1..SIZE_CAP (the smaller of DEPTH and SIZE_MAX)
  logic [SIZE_W-1:0]      size_c;
  logic [IDX_W:0]         ring_inc;
  logic [IDX_W-1:0]       ring_next;
  logic                   acc;

  // fields of the entry read back
  logic                   ent_valid;
  logic [REFS_W-1:0]      ent_refs;
  logic [TIME_BITS-1:0]   ent_created;
  logic [TIME_BITS-1:0]   ent_age;
  logic                   slot_oor;
  logic [REFS_W-1:0]      refs_dec;
  logic                   sweep_kill;

  always_comb begin
    if (max_size_r == '0) begin
      size_c = SIZE_W'(1);
    end else if (32'(max_size_r) > 32'(SIZE_CAP)) begin
      size_c = SIZE_W'(SIZE_CAP);
    end else begin
      size_c = max_size_r;
    end
  end

  // round-robin step, a pointer at or past the size wraps to slot 0
  assign ring_inc  = {1'b0, next_slot_r} + (IDX_W+1)'(1);
  assign ring_next = (32'(ring_inc) >= 32'(size_c)) ? '0 : ring_inc[IDX_W-1:0];

  assign acc       = start && (state_r == rrss_pkg::S_IDLE);
  assign busy      = (state_r != rrss_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  assign ent_valid   = rd_data_r[V_BIT];
  assign ent_refs    = rd_data_r[R_LSB +: REFS_W];
  assign ent_created = rd_data_r[TIME_BITS-1:0];
  assign ent_age     = now_r - ent_created;
  assign slot_oor    = ({1'b0, slot_r} >= size_c);
  assign refs_dec    = ent_refs - REFS_W'(1);
  assign sweep_kill  = ent_valid && (ent_refs == '0)
                       && (CMP_W'(ent_age) >= CMP_W'(youth_r));

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    next_slot_nxt  = next_slot_r;
    next_id_nxt    = next_id_r;
    cnt_nxt        = cnt_r;
    sw_rd_nxt      = sw_rd_r;
    sw_proc_nxt    = sw_proc_r;
    purged_nxt     = purged_r;
    mem_we         = 1'b0;
    mem_waddr      = tgt_r;
    mem_wdata      = rd_data_r;
    mem_re         = 1'b0;
    mem_raddr      = IDX_W'(in_slot);
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = out_slot_r;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_repl_nxt   = out_repl_r;
    out_purged_nxt = out_purged_r;
    out_cnt_nxt    = out_cnt_r;
    out_refs_nxt   = out_refs_r;

    case (state_r)
      rrss_pkg::S_CLEAR: begin
        // clearing pass: every slot starts empty
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = rrss_pkg::S_IDLE;
        end
      end

      rrss_pkg::S_IDLE: begin
        if (acc) begin
          mem_re = 1'b1;
          case (rrss_pkg::cmd_t'(in_cmd))
            rrss_pkg::CMD_CREATE: begin
              mem_raddr     = ring_next;
              next_slot_nxt = ring_next;
              state_nxt     = rrss_pkg::S_RMW;
            end
            rrss_pkg::CMD_SWEEP: begin
              mem_raddr   = '0;
              sw_rd_nxt   = SIZE_W'(1);
              sw_proc_nxt = '0;
              purged_nxt  = '0;
              state_nxt   = rrss_pkg::S_SWEEP;
            end
            default: begin
              mem_raddr = IDX_W'(in_slot);
              state_nxt = rrss_pkg::S_RMW;
            end
          endcase
        end
      end

      rrss_pkg::S_RMW: begin
        // read data of the addressed slot is in rd_data_r
        state_nxt      = rrss_pkg::S_IDLE;
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = slot_r;
        out_id_nxt     = '0;
        out_status_nxt = rrss_pkg::ST_OK;
        out_repl_nxt   = 1'b0;
        out_purged_nxt = '0;
        out_refs_nxt   = '0;
        case (cmd_r)
          rrss_pkg::CMD_CREATE: begin
            // fresh entry, an occupant is purged and replaced in one write
            next_id_nxt    = next_id_r + rrss_pkg::ID_W'(1);
            out_id_nxt     = next_id_nxt;
            out_slot_nxt   = rrss_pkg::SLOT_W'(tgt_r);
            mem_we         = 1'b1;
            mem_wdata      = {1'b1, REFS_W'(0), arrival_r};
            if (ent_valid) begin
              out_repl_nxt   = 1'b1;
              out_purged_nxt = CNT_W'(1);
            end else begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          rrss_pkg::CMD_ADD_REF: begin
            if (slot_oor) begin
              out_status_nxt = rrss_pkg::ST_OUT_RANGE;
            end else if (!ent_valid) begin
              out_status_nxt = rrss_pkg::ST_SLOT_EMPTY;
            end else begin
              // saturating increment
              mem_we       = 1'b1;
              out_refs_nxt = (ent_refs == rrss_pkg::REFS_MAX) ? ent_refs
                             : ent_refs + REFS_W'(1);
              mem_wdata    = {1'b1, out_refs_nxt, ent_created};
            end
          end
          rrss_pkg::CMD_DROP_REF: begin
            if (slot_oor) begin
              out_status_nxt = rrss_pkg::ST_OUT_RANGE;
            end else if (!ent_valid) begin
              out_status_nxt = rrss_pkg::ST_SLOT_EMPTY;
            end else begin
              mem_we = 1'b1;
              if (ent_refs == '0) begin
                out_status_nxt = rrss_pkg::ST_REFS_ZERO;
              end
              if ((ent_refs == '0) || (refs_dec == '0)) begin
                // last reference gone, or drop at zero: purge
                mem_wdata      = {1'b0, REFS_W'(0), ent_created};
                cnt_nxt        = cnt_r - CNT_W'(1);
                out_purged_nxt = CNT_W'(1);
              end else begin
                mem_wdata    = {1'b1, refs_dec, ent_created};
                out_refs_nxt = refs_dec;
              end
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
        out_cnt_nxt = cnt_nxt;
      end

      rrss_pkg::S_SWEEP: begin
        // rd_data_r holds slot sw_proc_r, the next slot is read meanwhile
        if (sweep_kill) begin
          mem_we     = 1'b1;
          mem_waddr  = IDX_W'(sw_proc_r);
          mem_wdata  = {1'b0, REFS_W'(0), ent_created};
          cnt_nxt    = cnt_r - CNT_W'(1);
          purged_nxt = purged_r + CNT_W'(1);
        end
        if (sw_rd_r < size_c) begin
          mem_re      = 1'b1;
          mem_raddr   = IDX_W'(sw_rd_r);
          sw_proc_nxt = sw_rd_r;
          sw_rd_nxt   = sw_rd_r + SIZE_W'(1);
        end else begin
          state_nxt      = rrss_pkg::S_IDLE;
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = '0;
          out_id_nxt     = '0;
          out_status_nxt = rrss_pkg::ST_OK;
          out_repl_nxt   = 1'b0;
          out_purged_nxt = purged_nxt;
          out_cnt_nxt    = cnt_nxt;
          out_refs_nxt   = '0;
        end
      end

      default: begin
        state_nxt = rrss_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrss_pkg::S_CLEAR;
      clr_r       <= '0;
      next_slot_r <= IDX_W'(DEPTH - 1);
      next_id_r   <= rrss_pkg::ID_RST;
      cnt_r       <= '0;
      sw_rd_r     <= '0;
      sw_proc_r   <= '0;
      purged_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_slot_r <= next_slot_nxt;
      next_id_r   <= next_id_nxt;
      cnt_r       <= cnt_nxt;
      sw_rd_r     <= sw_rd_nxt;
      sw_proc_r   <= sw_proc_nxt;
      purged_r    <= purged_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= rrss_pkg::SIZE_RST;
      youth_r    <= rrss_pkg::YOUTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rrss_pkg::REG_MAX_STORE_SIZE: max_size_r <= cfg_data[SIZE_W-1:0];
        rrss_pkg::REG_YOUTH_TIME:     youth_r    <= cfg_data[31:0];
        default: begin
          youth_r <= youth_r;
        end
      endcase
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r     <= rrss_pkg::cmd_t'(in_cmd);
      slot_r    <= in_slot;
      arrival_r <= TIME_BITS'(in_arrival_time);
      now_r     <= TIME_BITS'(in_now_time);
      tgt_r     <= (rrss_pkg::cmd_t'(in_cmd) == rrss_pkg::CMD_CREATE) ? ring_next
                   : IDX_W'(in_slot);
    end
    out_slot_r   <= out_slot_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_repl_r   <= out_repl_nxt;
    out_purged_r <= out_purged_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_refs_r   <= out_refs_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_slot_used    = out_slot_r;
  assign out_store_id     = out_id_r;
  assign out_status       = out_status_r;
  assign out_replaced     = out_repl_r;
  assign out_purged_count = out_purged_r;
  assign out_entry_count  = out_cnt_r;
  assign out_refs_after   = out_refs_r;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for refcounted_ring_slot_store
// drives create, add, drop and sweep requests through the start/busy channel,
// predicts each result with a behavioral copy of the slot ring or a fixed script
// row, compares each strobe field by field; registers are rewritten between phases
// ----------------------------------------------------------------------------
module testbench;

  // one result as the block reports it
  typedef struct packed {
    logic [rrss_pkg::SLOT_W-1:0] slot_used;
    logic [rrss_pkg::ID_W-1:0]   store_id;
    rrss_pkg::status_t           status;
    logic                        replaced;
    logic [rrss_pkg::CNT_W-1:0]  purged;
    logic [rrss_pkg::CNT_W-1:0]  entries;
    logic [rrss_pkg::REFS_W-1:0] refs;
  } outcome_t;

  // one line of the directed script; fixed rows carry the result typed in
  typedef struct packed {
    logic                            has_cfg;
    logic [rrss_pkg::CFG_IDX_W-1:0]  reg_sel;
    logic [rrss_pkg::CFG_DATA_W-1:0] reg_val;
    rrss_pkg::cmd_t                  cmd;
    logic [rrss_pkg::SLOT_W-1:0]     slot;
    logic [rrss_pkg::IN_TIME_W-1:0]  arrival;
    logic [rrss_pkg::IN_TIME_W-1:0]  now;
    logic                            fixed;
    outcome_t                        want;
  } script_row_t;

  localparam int SCRIPT_LEN   = 25;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 132;
  localparam int SETTLE_TAIL  = 300;
  localparam int REPORT_LIMIT = 10;
  localparam int REF_BURST    = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // block inputs, all known from time zero
  logic                            start           = 1'b0;
  logic [1:0]                      in_cmd          = '0;
  logic [rrss_pkg::SLOT_W-1:0]     in_slot         = '0;
  logic [rrss_pkg::IN_TIME_W-1:0]  in_arrival_time = '0;
  logic [rrss_pkg::IN_TIME_W-1:0]  in_now_time     = '0;
  logic                            cfg_valid       = 1'b0;
  logic [rrss_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [rrss_pkg::CFG_DATA_W-1:0] cfg_data        = '0;

  logic                            busy;
  logic                            out_valid;
  logic [rrss_pkg::SLOT_W-1:0]     out_slot_used;
  logic [rrss_pkg::ID_W-1:0]       out_store_id;
  logic [1:0]                      out_status;
  logic                            out_replaced;
  logic [rrss_pkg::CNT_W-1:0]      out_purged_count;
  logic [rrss_pkg::CNT_W-1:0]      out_entry_count;
  logic [rrss_pkg::REFS_W-1:0]     out_refs_after;
  logic                            cfg_ready;

  refcounted_ring_slot_store dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_slot          (in_slot),
    .in_arrival_time  (in_arrival_time),
    .in_now_time      (in_now_time),
    .out_valid        (out_valid),
    .out_slot_used    (out_slot_used),
    .out_store_id     (out_store_id),
    .out_status       (out_status),
    .out_replaced     (out_replaced),
    .out_purged_count (out_purged_count),
    .out_entry_count  (out_entry_count),
    .out_refs_after   (out_refs_after),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // behavioral copy of the slot ring
  // --------------------------------------------------------------------------
  bit                             ring_live [rrss_pkg::DEPTH_DEF];
  logic [rrss_pkg::REFS_W-1:0]    ring_refs [rrss_pkg::DEPTH_DEF];
  logic [rrss_pkg::IN_TIME_W-1:0] ring_born [rrss_pkg::DEPTH_DEF];
  logic [rrss_pkg::ID_W-1:0]      id_counter;
  logic [rrss_pkg::SLOT_W-1:0]    ring_ptr;
  logic [rrss_pkg::CNT_W-1:0]     live_entries;
  logic [rrss_pkg::SIZE_W-1:0]    size_reg;
  logic [31:0]                    youth_reg;

  // results still owed by the block, oldest first
  outcome_t owed_results [$];
  int       faults = 0;

  // slots in use: a size of zero acts as one, anything above the depth as the depth
  function automatic int ring_span();
    if (size_reg == 0) return 1;
    if (size_reg > rrss_pkg::DEPTH_DEF) return rrss_pkg::DEPTH_DEF;
    return int'(size_reg);
  endfunction

  // slot that the next create takes, the pointer wraps once it runs past the span
  function automatic int next_ring_slot();
    int n;
    n = int'(ring_ptr) + 1;
    if (n >= ring_span()) n = 0;
    return n;
  endfunction

  function automatic void purge_entry(int i);
    if (ring_live[i]) begin
      ring_live[i] = 1'b0;
      ring_refs[i] = '0;
      live_entries = live_entries - 1'b1;
    end
  endfunction

  // advance the ring by one request and return what the block must report
  function automatic outcome_t apply_slot_command(rrss_pkg::cmd_t op,
                                                  logic [rrss_pkg::SLOT_W-1:0] idx,
                                                  logic [rrss_pkg::IN_TIME_W-1:0] arr,
                                                  logic [rrss_pkg::IN_TIME_W-1:0] now);
    outcome_t                       r;
    int                             span;
    int                             n;
    logic [rrss_pkg::IN_TIME_W-1:0] age;
    r = '0;
    span = ring_span();
    case (op)
      rrss_pkg::CMD_CREATE: begin
        n = next_ring_slot();
        ring_ptr = n[rrss_pkg::SLOT_W-1:0];
        id_counter = id_counter + 1'b1;
        // an occupant is thrown out whatever its count
        if (ring_live[n]) begin
          purge_entry(n);
          r.replaced = 1'b1;
          r.purged = 9'd1;
        end
        ring_live[n] = 1'b1;
        ring_refs[n] = '0;
        ring_born[n] = arr;
        live_entries = live_entries + 1'b1;
        r.slot_used = n[rrss_pkg::SLOT_W-1:0];
        r.store_id = id_counter;
      end
      rrss_pkg::CMD_ADD_REF, rrss_pkg::CMD_DROP_REF: begin
        r.slot_used = idx;
        if (int'(idx) >= span) begin
          r.status = rrss_pkg::ST_OUT_RANGE;
        end else if (!ring_live[idx]) begin
          r.status = rrss_pkg::ST_SLOT_EMPTY;
        end else if (op == rrss_pkg::CMD_ADD_REF) begin
          // count sticks at its maximum
          if (ring_refs[idx] != rrss_pkg::REFS_MAX) ring_refs[idx] = ring_refs[idx] + 1'b1;
          r.refs = ring_refs[idx];
        end else begin
          // a drop at zero is flagged and still purges
          if (ring_refs[idx] == 0) r.status = rrss_pkg::ST_REFS_ZERO;
          else ring_refs[idx] = ring_refs[idx] - 1'b1;
          if (ring_refs[idx] == 0) begin
            purge_entry(idx);
            r.purged = 9'd1;
          end else begin
            r.refs = ring_refs[idx];
          end
        end
      end
      default: begin
        // sweep: unreferenced entries in the span at least youth_time old
        for (int i = 0; i < span; i++) begin
          if (ring_live[i]) begin
            age = now - ring_born[i];
            if (age >= youth_reg && ring_refs[i] == 0) begin
              purge_entry(i);
              r.purged = r.purged + 1'b1;
            end
          end
        end
      end
    endcase
    r.entries = live_entries;
    return r;
  endfunction

  function automatic string describe(outcome_t o);
    return $sformatf("slot %0d id %h status %0d replaced %0d purged %0d entries %0d refs %0d",
                     o.slot_used, o.store_id, o.status, o.replaced, o.purged, o.entries,
                     o.refs);
  endfunction

  // --------------------------------------------------------------------------
  // request and register drivers, all called right after a rising edge
  // --------------------------------------------------------------------------

  // present one request and hold it until the block takes it; start stays high
  task automatic issue(rrss_pkg::cmd_t op, logic [rrss_pkg::SLOT_W-1:0] idx,
                       logic [rrss_pkg::IN_TIME_W-1:0] arr,
                       logic [rrss_pkg::IN_TIME_W-1:0] now, bit fixed, outcome_t want);
    outcome_t predicted;
    start           <= 1'b1;
    in_cmd          <= op;
    in_slot         <= idx;
    in_arrival_time <= arr;
    in_now_time     <= now;
    do @(posedge clk); while (busy);
    predicted = apply_slot_command(op, idx, arr, now);
    owed_results.push_back(fixed ? want : predicted);
  endtask

  // sender gap
  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending and wait for every owed result and an idle block
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0 || busy);
  endtask

  task automatic write_reg(logic [rrss_pkg::CFG_IDX_W-1:0] sel,
                           logic [rrss_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (sel == rrss_pkg::REG_MAX_STORE_SIZE) size_reg = val[rrss_pkg::SIZE_W-1:0];
    else youth_reg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // directed script, default registers until the first write
  // --------------------------------------------------------------------------
  localparam outcome_t NO_WANT = '0;

  script_row_t script [SCRIPT_LEN] = '{
    // requests on an empty ring
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_ADD_REF, 8'd0, 32'd0, 32'd0,
      1'b1, '{8'd0, 32'd0, rrss_pkg::ST_SLOT_EMPTY, 1'b0, 9'd0, 9'd0, 16'd0}},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_DROP_REF, 8'd255, 32'd0, 32'd0,
      1'b1, '{8'd255, 32'd0, rrss_pkg::ST_SLOT_EMPTY, 1'b0, 9'd0, 9'd0, 16'd0}},
    // first IDs start at zero, time extremes
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_CREATE, 8'd77, 32'd0,
      32'hFFFF_FFFF,
      1'b1, '{8'd0, 32'd0, rrss_pkg::ST_OK, 1'b0, 9'd0, 9'd1, 16'd0}},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_CREATE, 8'd255,
      32'hFFFF_FFFF, 32'd0,
      1'b1, '{8'd1, 32'd1, rrss_pkg::ST_OK, 1'b0, 9'd0, 9'd2, 16'd0}},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_ADD_REF, 8'd0, 32'd0, 32'd0,
      1'b1, '{8'd0, 32'd0, rrss_pkg::ST_OK, 1'b0, 9'd0, 9'd2, 16'd1}},
    // drop at zero flags and purges, drop to zero purges
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_DROP_REF, 8'd1, 32'd0, 32'd0,
      1'b1, '{8'd1, 32'd0, rrss_pkg::ST_REFS_ZERO, 1'b0, 9'd1, 9'd1, 16'd0}},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_DROP_REF, 8'd0, 32'd0, 32'd0,
      1'b1, '{8'd0, 32'd0, rrss_pkg::ST_OK, 1'b0, 9'd1, 9'd0, 16'd0}},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_SWEEP, 8'd0, 32'd0, 32'd0,
      1'b1, '{8'd0, 32'd0, rrss_pkg::ST_OK, 1'b0, 9'd0, 9'd0, 16'd0}},
    // age wraps: now one below the creation time is very old
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_CREATE, 8'd0, 32'd100, 32'd0,
      1'b1, '{8'd2, 32'd2, rrss_pkg::ST_OK, 1'b0, 9'd0, 9'd1, 16'd0}},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_SWEEP, 8'd0, 32'd0, 32'd99,
      1'b1, '{8'd0, 32'd0, rrss_pkg::ST_OK, 1'b0, 9'd1, 9'd0, 16'd0}},
    // youth boundary, one short and exact
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_CREATE, 8'd0, 32'd5, 32'd0,
      1'b1, '{8'd3, 32'd3, rrss_pkg::ST_OK, 1'b0, 9'd0, 9'd1, 16'd0}},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_SWEEP, 8'd0, 32'd0,
      32'd1000004,
      1'b1, '{8'd0, 32'd0, rrss_pkg::ST_OK, 1'b0, 9'd0, 9'd1, 16'd0}},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_SWEEP, 8'd0, 32'd0,
      32'd1000005,
      1'b1, '{8'd0, 32'd0, rrss_pkg::ST_OK, 1'b0, 9'd1, 9'd0, 16'd0}},
    // size zero acts as one: creates keep replacing slot 0
    '{1'b1, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_CREATE, 8'd0, 32'd7, 32'd0,
      1'b0, NO_WANT},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_CREATE, 8'd0, 32'd8, 32'd0,
      1'b0, NO_WANT},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_ADD_REF, 8'd1, 32'd0, 32'd0,
      1'b0, NO_WANT},
    // size above the depth acts as the depth
    '{1'b1, rrss_pkg::REG_MAX_STORE_SIZE, 32'h1FF, rrss_pkg::CMD_CREATE, 8'd0, 32'd9, 32'd0,
      1'b0, NO_WANT},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_CREATE, 8'd0, 32'd10, 32'd0,
      1'b0, NO_WANT},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_CREATE, 8'd0, 32'd11, 32'd0,
      1'b0, NO_WANT},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_ADD_REF, 8'd3, 32'd0, 32'd0,
      1'b0, NO_WANT},
    // shrunk ring: slots 2 and 3 stay live but out of reach, pointer wraps
    '{1'b1, rrss_pkg::REG_MAX_STORE_SIZE, 32'd2, rrss_pkg::CMD_DROP_REF, 8'd3, 32'd0, 32'd0,
      1'b0, NO_WANT},
    '{1'b0, rrss_pkg::REG_MAX_STORE_SIZE, 32'd0, rrss_pkg::CMD_CREATE, 8'd0, 32'd12, 32'd0,
      1'b0, NO_WANT},
    '{1'b1, rrss_pkg::REG_YOUTH_TIME, 32'd0, rrss_pkg::CMD_SWEEP, 8'd0, 32'd0, 32'd0,
      1'b0, NO_WANT},
    '{1'b1, rrss_pkg::REG_MAX_STORE_SIZE, 32'd256, rrss_pkg::CMD_SWEEP, 8'd0, 32'd0, 32'd10,
      1'b0, NO_WANT},
    '{1'b1, rrss_pkg::REG_YOUTH_TIME, 32'hFFFF_FFFF, rrss_pkg::CMD_CREATE, 8'd0,
      32'h8000_0000, 32'd0, 1'b0, NO_WANT}
  };

  // --------------------------------------------------------------------------
  // result checker: results are registered, so mid-cycle sampling sees the
  // value taken at the closing edge without racing the request driver
  // --------------------------------------------------------------------------
  outcome_t observed;
  outcome_t oldest;

  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      observed = '{out_slot_used, out_store_id, rrss_pkg::status_t'(out_status), out_replaced,
                   out_purged_count, out_entry_count, out_refs_after};
      if (owed_results.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("%0t: result with no request outstanding: %s", $realtime,
                   describe(observed));
      end else begin
        oldest = owed_results.pop_front();
        if (observed !== oldest) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("%0t: result mismatch\n  expected %s\n  actual   %s", $realtime,
                     describe(oldest), describe(observed));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                              k;
    int                              ph;
    int                              pick;
    int                              target;
    int                              span;
    bit                              idle_on;
    bit                              calm;
    rrss_pkg::cmd_t                  op;
    logic [rrss_pkg::SLOT_W-1:0]     idx;
    logic [rrss_pkg::IN_TIME_W-1:0]  arr;
    logic [rrss_pkg::IN_TIME_W-1:0]  now;
    logic [rrss_pkg::IN_TIME_W-1:0]  stamp;
    logic [rrss_pkg::CFG_DATA_W-1:0] size_word;
    logic [31:0]                     youth_word;

    // ring state after reset
    for (int i = 0; i < rrss_pkg::DEPTH_DEF; i++) begin
      ring_live[i] = 1'b0;
      ring_refs[i] = '0;
      ring_born[i] = '0;
    end
    id_counter   = rrss_pkg::ID_RST;
    ring_ptr     = rrss_pkg::SLOT_W'(rrss_pkg::DEPTH_DEF - 1);
    live_entries = '0;
    size_reg     = rrss_pkg::SIZE_RST;
    youth_reg    = rrss_pkg::YOUTH_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed script; the first request waits out the clearing pass on busy
    for (k = 0; k < SCRIPT_LEN; k++) begin
      if (script[k].has_cfg) begin
        settle();
        write_reg(script[k].reg_sel, script[k].reg_val);
      end
      issue(script[k].cmd, script[k].slot, script[k].arrival, script[k].now,
            script[k].fixed, script[k].want);
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 14));
    end

    // count up and down on one slot, back to back
    settle();
    write_reg(rrss_pkg::REG_MAX_STORE_SIZE, 32'd256);
    target = next_ring_slot();
    issue(rrss_pkg::CMD_CREATE, 8'($urandom), $urandom, $urandom, 1'b0, NO_WANT);
    for (k = 0; k < REF_BURST; k++)
      issue(rrss_pkg::CMD_ADD_REF, target[rrss_pkg::SLOT_W-1:0], $urandom, $urandom,
            1'b0, NO_WANT);
    repeat (3) issue(rrss_pkg::CMD_DROP_REF, target[rrss_pkg::SLOT_W-1:0], $urandom,
                     $urandom, 1'b0, NO_WANT);
    issue(rrss_pkg::CMD_ADD_REF, target[rrss_pkg::SLOT_W-1:0], $urandom, $urandom,
          1'b0, NO_WANT);

    // fill the whole ring then sweep it empty in one request
    settle();
    write_reg(rrss_pkg::REG_YOUTH_TIME, 32'd0);
    repeat (rrss_pkg::DEPTH_DEF)
      issue(rrss_pkg::CMD_CREATE, 8'($urandom), $urandom, $urandom, 1'b0, NO_WANT);
    issue(rrss_pkg::CMD_SWEEP, 8'($urandom), $urandom, $urandom, 1'b0, NO_WANT);

    // random phases over a spread of register settings
    stamp = $urandom;
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       begin size_word = 32'd4;   youth_word = 32'd0;        end
        1:       begin size_word = 32'd1;   youth_word = 32'd1000;     end
        2:       begin size_word = 32'd256; youth_word = rrss_pkg::YOUTH_RST; end
        3:       begin size_word = 32'd0;   youth_word = 32'hFFFF_FFFF; end
        4:       begin size_word = 32'h1FF; youth_word = 32'd5000;     end
        5:       begin size_word = 32'd16;  youth_word = $urandom;     end
        6:       begin size_word = $urandom_range(2, 255); youth_word = 32'd200; end
        default: begin size_word = 32'd3;   youth_word = 32'd0;        end
      endcase
      // upper bits of the size word are junk the block must drop
      size_word = (size_word & 32'h0000_01FF) | ($urandom << rrss_pkg::SIZE_W);
      write_reg(rrss_pkg::REG_MAX_STORE_SIZE, size_word);
      write_reg(rrss_pkg::REG_YOUTH_TIME, youth_word);
      span    = ring_span();
      idle_on = (ph != PHASES - 1);   // last phase runs flat out
      calm    = 1'b0;

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 49) == 0) stamp = $urandom;
        else stamp = stamp + $urandom_range(0, 3000);

        pick = $urandom_range(0, 99);
        if (pick < 35) op = rrss_pkg::CMD_CREATE;
        else if (pick < 60) op = rrss_pkg::CMD_ADD_REF;
        else if (pick < 85) op = rrss_pkg::CMD_DROP_REF;
        else op = rrss_pkg::CMD_SWEEP;

        // mostly slots in reach, often the newest entry, sometimes anything
        pick = $urandom_range(0, 9);
        if (pick < 6) idx = rrss_pkg::SLOT_W'($urandom_range(0, span - 1));
        else if (pick < 8) idx = ring_ptr;
        else idx = rrss_pkg::SLOT_W'($urandom);

        arr = ($urandom_range(0, 6) != 0) ? stamp : $urandom;

        // sweep times around the youth boundary of the newest entry
        pick = $urandom_range(0, 9);
        if (pick < 3) now = stamp;
        else if (pick < 5) now = ring_born[ring_ptr] + youth_reg;
        else if (pick < 7) now = ring_born[ring_ptr] + youth_reg - 1'b1;
        else if (pick < 8) now = $urandom;
        else now = stamp + $urandom_range(0, youth_reg);

        issue(op, idx, arr, now, 1'b0, NO_WANT);

        // in phase 2, halfway through, hold the sender until every owed result is in
        if (ph == 2 && k == PHASE_ITEMS / 2) begin
          settle();
        end else if (idle_on) begin
          if ($urandom_range(0, 29) == 0) calm = !calm;
          if (!calm && $urandom_range(0, 3) == 0) pause($urandom_range(1, 14));
        end
      end
    end

    settle();
    // room for a stray result from a full-length sweep
    repeat (SETTLE_TAIL) @(posedge clk);
    if (faults == 0 && owed_results.size() == 0) begin
      $display("refcounted_ring_slot_store test passed");
    end else begin
      $display("refcounted_ring_slot_store test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #60_000_000;
    $display("refcounted_ring_slot_store test failed");
    $finish;
  end

endmodule
